// File: rtl/cqfp_pkg.sv
package cqfp_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W       = 16;
  localparam int PRIO_W     = 4;
  localparam int TIME_W     = 32;
  localparam int CAP_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_PRIO = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE = 2'd0,
    REG_CAP  = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STAT_PUSHED = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_POPPED = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] tstamp;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    push_wr;
    logic    scan_start;
    logic    scan_step;
    logic    shift_start;
    logic    shift_step;
    logic    pop_done;
    logic    res_load;
    status_t res_code;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pop;
    logic count_zero;
    logic full;
    logic scan_done;
    logic shift_done;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: rtl/cqfp_ifs.sv
interface cqfp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [cqfp_pkg::ID_W-1:0]    conn_id;
  logic [cqfp_pkg::PRIO_W-1:0]  priority_req;
  logic [cqfp_pkg::TIME_W-1:0]  arrival_time;

  modport source (output valid, command, conn_id, priority_req, arrival_time, input ready);
  modport sink   (input valid, command, conn_id, priority_req, arrival_time, output ready);
endinterface

interface cqfp_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [cqfp_pkg::ID_W-1:0]    out_id;
  logic [cqfp_pkg::PRIO_W-1:0]  out_priority;
  logic [cqfp_pkg::TIME_W-1:0]  out_time;

  modport source (output valid, status, out_id, out_priority, out_time, input ready);
  modport sink   (input valid, status, out_id, out_priority, out_time, output ready);
endinterface

// File: rtl/cqfp_datapath.sv
module cqfp_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cqfp_pkg::dp_cmd_t                 cmd,
  output cqfp_pkg::dp_stat_t                stat,
  input  logic                              in_command,
  input  logic [cqfp_pkg::ID_W-1:0]         in_id,
  input  logic [cqfp_pkg::PRIO_W-1:0]       in_prio,
  input  logic [cqfp_pkg::TIME_W-1:0]       in_time,
  input  logic                              cfg_we,
  input  logic [cqfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cqfp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic [cqfp_pkg::ID_W-1:0]         out_id,
  output logic [cqfp_pkg::PRIO_W-1:0]       out_prio,
  output logic [cqfp_pkg::TIME_W-1:0]       out_time
);

  cqfp_pkg::entry_t mem [cqfp_pkg::QUEUE_DEPTH];

  logic                            mode_r;
  logic [cqfp_pkg::CAP_W-1:0]      cap_r;
  logic [cqfp_pkg::CNT_W-1:0]      count_r;
  cqfp_pkg::entry_t                item_r;
  logic                            cmd_r;
  logic [cqfp_pkg::CNT_W-1:0]      ptr_r;
  logic                            rdv_r;
  logic [cqfp_pkg::IDX_W-1:0]      rdq_r;
  cqfp_pkg::entry_t                rdata_r;
  cqfp_pkg::entry_t                best_r;
  logic [cqfp_pkg::IDX_W-1:0]      best_idx_r;
  logic                            out_valid_r;
  cqfp_pkg::status_t               out_status_r;
  cqfp_pkg::entry_t                out_entry_r;

  logic [cqfp_pkg::CNT_W-1:0]      limit;
  logic                            rd_en;
  logic [cqfp_pkg::IDX_W-1:0]      raddr;
  logic                            take;
  logic                            we;
  logic [cqfp_pkg::IDX_W-1:0]      waddr;
  cqfp_pkg::entry_t                wdata;

  // FIFO mode looks at the head only
  assign limit = (mode_r == cqfp_pkg::MODE_PRIO) ? count_r : cqfp_pkg::CNT_W'(1);
  assign rd_en = (cmd.scan_step && (ptr_r < limit)) || (cmd.shift_step && (ptr_r < count_r));
  assign raddr = ptr_r[cqfp_pkg::IDX_W-1:0];
  assign take  = cmd.scan_step && rdv_r &&
                 ((rdq_r == '0) || (rdata_r.prio > best_r.prio));

  assign we    = cmd.push_wr || (cmd.shift_step && rdv_r);
  assign waddr = cmd.push_wr ? count_r[cqfp_pkg::IDX_W-1:0] : (rdq_r - 1'b1);
  assign wdata = cmd.push_wr ? item_r : rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
      rdq_r   <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= cqfp_pkg::MODE_FIFO;
      cap_r       <= cqfp_pkg::CAP_RESET;
      count_r     <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cqfp_pkg::cfg_reg_t'(cfg_index))
          cqfp_pkg::REG_MODE: mode_r <= cfg_data[0];
          cqfp_pkg::REG_CAP:  cap_r  <= cfg_data;
          default: ;
        endcase
      end
      rdv_r <= rd_en;
      if (cmd.push_wr) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.pop_done) begin
        count_r <= count_r - 1'b1;
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r.id     <= in_id;
      item_r.prio   <= in_prio;
      item_r.tstamp <= in_time;
      cmd_r         <= in_command;
    end
    if (cmd.scan_start) begin
      ptr_r <= '0;
    end else if (cmd.shift_start) begin
      // close up from the slot after the one taken
      ptr_r <= cqfp_pkg::CNT_W'(best_idx_r) + 1'b1;
    end else if (rd_en) begin
      ptr_r <= ptr_r + 1'b1;
    end
    if (take) begin
      best_r     <= rdata_r;
      best_idx_r <= rdq_r;
    end
    if (cmd.res_load) begin
      out_status_r <= cmd.res_code;
      out_entry_r  <= (cmd.res_code == cqfp_pkg::STAT_POPPED) ? best_r : '0;
    end
  end

  always_comb begin
    stat.is_pop     = (cmd_r == cqfp_pkg::CMD_POP);
    stat.count_zero = (count_r == '0);
    stat.full       = (cqfp_pkg::CMP_W'(count_r) >= cqfp_pkg::CMP_W'(cap_r)) ||
                      (count_r >= cqfp_pkg::CNT_W'(cqfp_pkg::QUEUE_DEPTH));
    stat.scan_done  = (ptr_r >= limit) && !rdv_r;
    stat.shift_done = (ptr_r >= count_r) && !rdv_r;
    stat.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_entry_r.id;
  assign out_prio   = out_entry_r.prio;
  assign out_time   = out_entry_r.tstamp;

endmodule

// File: rtl/cqfp_ctrl.sv
module cqfp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cqfp_pkg::dp_stat_t stat,
  output cqfp_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  cqfp_pkg::status_t res_r, res_nxt;

  always_comb begin
    cmd          = '0;
    cmd.res_code = res_r;
    state_nxt    = state_r;
    res_nxt      = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!stat.is_pop) begin
          if (stat.full) begin
            res_nxt = cqfp_pkg::STAT_FULL;
          end else begin
            cmd.push_wr = 1'b1;
            res_nxt     = cqfp_pkg::STAT_PUSHED;
          end
          state_nxt = ST_FINISH;
        end else if (stat.count_zero) begin
          res_nxt   = cqfp_pkg::STAT_EMPTY;
          state_nxt = ST_FINISH;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          cmd.shift_start = 1'b1;
          state_nxt       = ST_SHIFT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (stat.shift_done) begin
          cmd.pop_done = 1'b1;
          res_nxt      = cqfp_pkg::STAT_POPPED;
          state_nxt    = ST_FINISH;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      res_r   <= cqfp_pkg::STAT_PUSHED;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

// File: rtl/connection_queue_fifo_or_priority_unit.sv
// Bounded queue of connection entries (id, priority, timestamp) in a single-port-read
// entry memory of QUEUE_DEPTH slots. Command 0 pushes at the tail (status full once the
// count reaches the capacity register or the depth); command 1 pops the head in FIFO
// mode, or the earliest entry of strictly highest priority in priority mode, and the
// entries behind it close up one slot each. One item is in work at a time, and a result
// may wait in the output register while the next item is taken. A push, a rejected push
// or a pop on empty goes from the decide state straight to the finish state. A pop
// scans the head only in FIFO mode or every entry in priority mode, then copies each
// entry behind the slot taken down by one: the memory's one read port is used once per
// entry, first for the priority scan and then for the close-up copy. The entry memory
// needs no clearing after reset; configuration writes take effect at once.
module connection_queue_fifo_or_priority_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  cqfp_in_if.sink                          in_ch,
  cqfp_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [cqfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cqfp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  cqfp_pkg::dp_cmd_t  cmd;
  cqfp_pkg::dp_stat_t stat;

  cqfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cqfp_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_command (in_ch.command),
    .in_id      (in_ch.conn_id),
    .in_prio    (in_ch.priority_req),
    .in_time    (in_ch.arrival_time),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_id     (out_ch.out_id),
    .out_prio   (out_ch.out_priority),
    .out_time   (out_ch.out_time)
  );

endmodule
